>>> rtl/core/rgbfb_pkg.sv
package rgbfb_pkg;

  // default image bounds
  localparam int DEFAULT_MAX_WIDTH  = 128;
  localparam int DEFAULT_MAX_HEIGHT = 128;

  // depth of the command queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [7:0]  RST_WIDTH  = 8'd128;
  localparam logic [7:0]  RST_HEIGHT = 8'd128;

  // apb address width: seven registers at 4-byte spacing
  localparam int PADDR_W = 5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2,
    OP_EMIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    XF_NONE   = 2'd0,
    XF_MIRR_H = 2'd1,
    XF_MIRR_V = 2'd2,
    XF_ROT180 = 2'd3
  } xform_e;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_DEST_X  = 3'd2,
    REG_DEST_Y  = 3'd3,
    REG_XFORM   = 3'd4,
    REG_KEY_COL = 3'd5,
    REG_KEY_EN  = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_FILL
  } back_state_e;

  // configuration register set
  typedef struct packed {
    logic [7:0]  width_in_use;
    logic [7:0]  height_in_use;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    xform_e      transform_mode;
    logic [15:0] key_color;
    logic        key_enable;
  } cfg_t;

  // classified command handed from front to back (address travels beside it)
  typedef struct packed {
    op_e         op;
    logic        in_img;
    logic [7:0]  color;
    logic [15:0] out_x;
    logic [15:0] out_y;
  } cmd_t;

  // back status toward the top level
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // rgb565 to rgb332: keep the top bits of each channel
  function automatic logic [7:0] to332(input logic [15:0] c);
    return {c[15:13], c[10:8], c[4:3]};
  endfunction

  // rgb332 to rgb565: red and green low bits filled from the channel lsb, blue from either bit
  function automatic logic [15:0] to565(input logic [7:0] c);
    return {c[7:5], {2{c[5]}}, c[4:2], {3{c[2]}}, c[1:0], {3{|c[1:0]}}};
  endfunction

endpackage

>>> rtl/core/rgbfb_front.sv
module rgbfb_front #(
  parameter int MAX_WIDTH  = rgbfb_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbfb_pkg::DEFAULT_MAX_HEIGHT,
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  rgbfb_pkg::op_e      operation_i,
  input  logic signed [15:0]  pix_x_i,
  input  logic signed [15:0]  pix_y_i,
  input  logic [15:0]         pix_color_i,
  input  rgbfb_pkg::cfg_t     cfg_i,
  output rgbfb_pkg::cmd_t     cmd_o,
  output logic [ADDR_W-1:0]   addr_o
);
  import rgbfb_pkg::*;

  localparam int PROD_W = $clog2(DEPTH + 1);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int XI_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YI_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [WD_W-1:0]   w;
  logic [HT_W-1:0]   h;
  logic              in_img;
  logic              is_fill;
  logic [PROD_W-1:0] mul_a;
  logic [PROD_W-1:0] prod;
  logic [15:0]       sx;
  logic [15:0]       sy;
  logic              mir_x;
  logic              mir_y;

  // clamp the image size to 1..max
  always_comb begin
    if (cfg_i.width_in_use == 8'd0) begin
      w = WD_W'(1);
    end else if (32'(cfg_i.width_in_use) > MAX_WIDTH) begin
      w = WD_W'(MAX_WIDTH);
    end else begin
      w = WD_W'(cfg_i.width_in_use);
    end
    if (cfg_i.height_in_use == 8'd0) begin
      h = HT_W'(1);
    end else if (32'(cfg_i.height_in_use) > MAX_HEIGHT) begin
      h = HT_W'(MAX_HEIGHT);
    end else begin
      h = HT_W'(cfg_i.height_in_use);
    end
  end

  // bounds check on the signed coordinate
  assign in_img = !pix_x_i[15] && !pix_y_i[15] &&
                  ({1'b0, pix_x_i[14:0]} < 16'(w)) &&
                  ({1'b0, pix_y_i[14:0]} < 16'(h));

  // one shared multiplier: row base for pixels, pixel count for fill
  assign is_fill = (operation_i == OP_FILL);
  assign mul_a   = is_fill ? PROD_W'(h) : PROD_W'(pix_y_i[YI_W-1:0]);
  assign prod    = mul_a * PROD_W'(w);

  always_comb begin
    if (is_fill) begin
      addr_o = ADDR_W'(prod - PROD_W'(1));
    end else if (in_img) begin
      addr_o = ADDR_W'(prod + PROD_W'(pix_x_i[XI_W-1:0]));
    end else begin
      addr_o = '0;
    end
  end

  // mirror within the image, then add the offset
  assign mir_x = (cfg_i.transform_mode == XF_MIRR_H) || (cfg_i.transform_mode == XF_ROT180);
  assign mir_y = (cfg_i.transform_mode == XF_MIRR_V) || (cfg_i.transform_mode == XF_ROT180);
  assign sx    = mir_x ? (16'(w) - 16'd1 - pix_x_i) : pix_x_i;
  assign sy    = mir_y ? (16'(h) - 16'd1 - pix_y_i) : pix_y_i;

  always_comb begin
    cmd_o.op     = operation_i;
    cmd_o.in_img = in_img;
    cmd_o.color  = to332(pix_color_i);
    if (operation_i == OP_EMIT) begin
      cmd_o.out_x = sx + cfg_i.dest_x;
      cmd_o.out_y = sy + cfg_i.dest_y;
    end else begin
      cmd_o.out_x = '0;
      cmd_o.out_y = '0;
    end
  end

endmodule

>>> rtl/core/rgbfb_queue.sv
module rgbfb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);
  import rgbfb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/rgbfb_back.sv
module rgbfb_back #(
  parameter int MAX_WIDTH  = rgbfb_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbfb_pkg::DEFAULT_MAX_HEIGHT,
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  rgbfb_pkg::cmd_t         head_cmd_i,
  input  logic [ADDR_W-1:0]       head_addr_i,
  output logic                    pop_o,
  input  logic [15:0]             key_color_i,
  input  logic                    key_enable_i,
  output rgbfb_pkg::back_status_t status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [15:0]             out_color_o,
  output logic signed [15:0]      out_x_o,
  output logic signed [15:0]      out_y_o,
  output logic                    visible_o,
  output logic                    in_range_o
);
  import rgbfb_pkg::*;

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [7:0]        fill_col_q, fill_col_d;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;

  logic              pend_valid_q;
  cmd_t              pend_q;
  logic              out_free;
  logic              pend_adv;
  logic              pend_free;
  logic [15:0]       c565;

  logic              out_valid_q;
  logic [15:0]       out_color_q;
  logic [15:0]       out_x_q;
  logic [15:0]       out_y_q;
  logic              visible_q;
  logic              in_range_q;

  // read pipeline flow
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pend_adv  = pend_valid_q && out_free;
  assign pend_free = !pend_valid_q || pend_adv;

  // sequencer: clearing pass, command dispatch, fill sweep
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    fill_col_d = fill_col_q;
    we         = 1'b0;
    waddr      = head_addr_i;
    wdata      = head_cmd_i.color;
    re         = 1'b0;
    pop_o      = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (head_valid_i) begin
          unique case (head_cmd_i.op) inside
            OP_WRITE: begin
              pop_o = 1'b1;
              we    = head_cmd_i.in_img;
            end
            OP_FILL: begin
              pop_o      = 1'b1;
              cnt_d      = '0;
              last_d     = head_addr_i;
              fill_col_d = head_cmd_i.color;
              state_d    = BK_FILL;
            end
            OP_READ, OP_EMIT: begin
              pop_o = pend_free;
              re    = pend_free;
            end
            default: begin
            end
          endcase
        end
      end
      BK_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = fill_col_q;
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == last_q) begin
          state_d = BK_RUN;
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    fill_col_q <= fill_col_d;
  end

  // pixel store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[head_addr_i];
    end
  end

  // pending read stage waits for the store data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (re) begin
      pend_valid_q <= 1'b1;
    end else if (pend_adv) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      pend_q <= head_cmd_i;
    end
  end

  // result formatting
  assign c565 = pend_q.in_img ? to565(rdata_q) : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_adv) begin
      out_color_q <= c565;
      out_x_q     <= pend_q.out_x;
      out_y_q     <= pend_q.out_y;
      visible_q   <= (pend_q.op == OP_EMIT) && pend_q.in_img &&
                     !(key_enable_i && (c565 == key_color_i));
      in_range_q  <= pend_q.in_img;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_color_o       = out_color_q;
  assign out_x_o           = out_x_q;
  assign out_y_o           = out_y_q;
  assign visible_o         = visible_q;
  assign in_range_o        = in_range_q;
  assign status_o.clearing = (state_q == BK_CLEAR);

endmodule

>>> rtl/core/rgb332_framebuffer.sv
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_stall_o   operation_i, pix_x_i, pix_y_i, pix_color_i
// result    out        out_valid_o / out_stall_i out_color_o, out_x_o, out_y_o, visible_o,
//                                                in_range_o
// config    in         apb write/read            paddr, pwdata, prdata
//
// write, read and emit are each handled in one back-end step, a read or emit only while
// the pending read stage can take it; a read or emit result passes the queue, the store
// read and the output register. fill holds the back end while it writes every image pixel,
// one store write per pixel. after reset a clearing pass writes every store entry while
// in_stall_o stays high; config writes are taken throughout.
// a two-entry command queue sits between classification and store access.
module rgb332_framebuffer #(
  parameter int MAX_WIDTH  = rgbfb_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbfb_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgbfb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [15:0]            pix_x_i,
  input  logic signed [15:0]            pix_y_i,
  input  logic [15:0]                   pix_color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   out_color_o,
  output logic signed [15:0]            out_x_o,
  output logic signed [15:0]            out_y_o,
  output logic                          visible_o,
  output logic                          in_range_o
);
  import rgbfb_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW     = $bits(cmd_t) + ADDR_W;

  cfg_t              cfg_q;
  reg_e              reg_sel;
  logic              cfg_wr;
  cmd_t              f_cmd;
  logic [ADDR_W-1:0] f_addr;
  logic              q_full;
  logic              q_valid;
  logic [QW-1:0]     q_head;
  logic              q_pop;
  cmd_t              h_cmd;
  logic [ADDR_W-1:0] h_addr;
  logic              in_xfer;
  back_status_t      bk_status;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_in_use   <= RST_WIDTH;
      cfg_q.height_in_use  <= RST_HEIGHT;
      cfg_q.dest_x         <= '0;
      cfg_q.dest_y         <= '0;
      cfg_q.transform_mode <= XF_NONE;
      cfg_q.key_color      <= '0;
      cfg_q.key_enable     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:   cfg_q.width_in_use   <= pwdata[7:0];
        REG_HEIGHT:  cfg_q.height_in_use  <= pwdata[7:0];
        REG_DEST_X:  cfg_q.dest_x         <= pwdata[15:0];
        REG_DEST_Y:  cfg_q.dest_y         <= pwdata[15:0];
        REG_XFORM:   cfg_q.transform_mode <= xform_e'(pwdata[1:0]);
        REG_KEY_COL: cfg_q.key_color      <= pwdata[15:0];
        REG_KEY_EN:  cfg_q.key_enable     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:   prdata = 32'(cfg_q.width_in_use);
      REG_HEIGHT:  prdata = 32'(cfg_q.height_in_use);
      REG_DEST_X:  prdata = 32'(cfg_q.dest_x);
      REG_DEST_Y:  prdata = 32'(cfg_q.dest_y);
      REG_XFORM:   prdata = 32'(cfg_q.transform_mode);
      REG_KEY_COL: prdata = 32'(cfg_q.key_color);
      REG_KEY_EN:  prdata = 32'(cfg_q.key_enable);
      default:     prdata = '0;
    endcase
  end

  // input side: no transfer during the clearing pass or with the queue full
  assign in_stall_o = q_full || bk_status.clearing;
  assign in_xfer    = in_valid_i && !in_stall_o;

  rgbfb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .operation_i(op_e'(operation_i)),
    .pix_x_i    (pix_x_i),
    .pix_y_i    (pix_y_i),
    .pix_color_i(pix_color_i),
    .cfg_i      (cfg_q),
    .cmd_o      (f_cmd),
    .addr_o     (f_addr)
  );

  rgbfb_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_xfer),
    .push_data_i({f_cmd, f_addr}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  assign h_cmd  = cmd_t'(q_head[QW-1:ADDR_W]);
  assign h_addr = q_head[ADDR_W-1:0];

  rgbfb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_cmd_i  (h_cmd),
    .head_addr_i (h_addr),
    .pop_o       (q_pop),
    .key_color_i (cfg_q.key_color),
    .key_enable_i(cfg_q.key_enable),
    .status_o    (bk_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_color_o (out_color_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .visible_o   (visible_o),
    .in_range_o  (in_range_o)
  );

endmodule

>>> rtl/core/rgbfb_checker.sv
module rgbfb_assert (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [15:0]                   out_color_o,
  input logic signed [15:0]            out_x_o,
  input logic signed [15:0]            out_y_o,
  input logic                          visible_o,
  input logic                          in_range_o
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_color_o) &&
      $stable(out_x_o) && $stable(out_y_o) && $stable(visible_o) && $stable(in_range_o))
    else $error("stalled result changed");

  // out of range results carry no color and are never visible
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> (out_color_o == 16'd0) && !visible_o)
    else $error("out of range result has color or visibility");

  // a visible pixel always comes from inside the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> in_range_o)
    else $error("visible result outside the image");

  // the store is being cleared right after reset, so input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input taken during clearing pass");

endmodule

bind rgb332_framebuffer rgbfb_assert u_rgbfb_assert (.*);

>>> tb/rgbfb_checker.sv
// watches the config port and both pixel channels, predicts every result
// from its own copy of the frame store and compares in order
module rgbfb_checker #(
  parameter int MAX_W = rgbfb_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_H = rgbfb_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [rgbfb_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          pready_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    operation_i,
  input  logic signed [15:0]            pix_x_i,
  input  logic signed [15:0]            pix_y_i,
  input  logic [15:0]                   pix_color_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [15:0]                   out_color_i,
  input  logic signed [15:0]            out_x_i,
  input  logic signed [15:0]            out_y_i,
  input  logic                          visible_i,
  input  logic                          in_range_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            transfers_o,
  output int                            results_o,
  output int                            fills_o
);
  import rgbfb_pkg::*;

  typedef struct packed {
    logic [15:0] color;
    logic [15:0] x;
    logic [15:0] y;
    logic        vis;
    logic        inr;
  } pixel_result_t;

  pixel_result_t pixel_result_q[$];
  logic [7:0]    frame_mem [MAX_W*MAX_H];

  // mirrored register set
  logic [7:0]  width_reg;
  logic [7:0]  height_reg;
  logic [15:0] dest_x_reg;
  logic [15:0] dest_y_reg;
  xform_e      xform_reg;
  logic [15:0] key_reg;
  logic        key_en_reg;

  int errors;
  int transfers;
  int results;
  int fills;

  // rgb565 down to one byte per pixel
  function automatic logic [7:0] pack_332(input logic [15:0] c);
    logic [7:0] p;
    p[7:5] = c[15:13];
    p[4:2] = c[10:8];
    p[1:0] = c[4:3];
    return p;
  endfunction

  // one byte back up to rgb565, red and green low bits copy the channel lsb, blue uses either bit
  function automatic logic [15:0] widen_565(input logic [7:0] p);
    logic [15:0] v;
    v = ({13'd0, p[7:5]} << 13) | ({13'd0, p[4:2]} << 8) | ({14'd0, p[1:0]} << 3);
    if (v[13]) v[12:11] = 2'b11;
    if (v[8]) v[7:5] = 3'b111;
    if (v[4] || v[3]) v[2:0] = 3'b111;
    return v;
  endfunction

  function automatic int clamp_dim(input logic [7:0] v, input int limit);
    if (v < 1) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  // update the store or queue the result one accepted item causes
  task automatic predict_pixel(input op_e op, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic [15:0] color);
    int            w;
    int            h;
    int            xi;
    int            yi;
    int            addr;
    logic          in_img;
    logic [15:0]   sx;
    logic [15:0]   sy;
    pixel_result_t r;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    xi = x;
    yi = y;
    in_img = (xi >= 0) && (yi >= 0) && (xi < w) && (yi < h);
    addr = in_img ? xi + yi * w : 0;
    case (op)
      OP_WRITE: begin
        if (in_img) frame_mem[addr] = pack_332(color);
      end
      OP_FILL: begin
        fills++;
        for (int i = 0; i < w * h; i++) frame_mem[i] = pack_332(color);
      end
      default: begin
        r = '0;
        if (in_img) begin
          r.color = widen_565(frame_mem[addr]);
          r.vis = !(key_en_reg && r.color == key_reg);
        end
        if (op == OP_EMIT) begin
          sx = x;
          sy = y;
          if (xform_reg == XF_MIRR_H || xform_reg == XF_ROT180) sx = 16'(w - 1 - xi);
          if (xform_reg == XF_MIRR_V || xform_reg == XF_ROT180) sy = 16'(h - 1 - yi);
          r.x = sx + dest_x_reg;
          r.y = sy + dest_y_reg;
        end else begin
          r.vis = 1'b0;
        end
        r.inr = in_img;
        pixel_result_q.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] expected,
                             input logic [15:0] actual);
    if (expected !== actual) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
    end
  endtask

  // compare one output transfer against the oldest prediction
  task automatic check_result();
    pixel_result_t r;
    results++;
    if (pixel_result_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, color %h x %h y %h visible %b in_range %b",
               $time, out_color_i, out_x_i, out_y_i, visible_i, in_range_i);
    end else begin
      r = pixel_result_q.pop_front();
      check_field("out_color", r.color, out_color_i);
      check_field("out_x", r.x, out_x_i);
      check_field("out_y", r.y, out_y_i);
      check_field("visible", {15'd0, r.vis}, {15'd0, visible_i});
      check_field("in_range", {15'd0, r.inr}, {15'd0, in_range_i});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_W * MAX_H; i++) frame_mem[i] = 8'd0;
      pixel_result_q.delete();
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      dest_x_reg = 16'd0;
      dest_y_reg = 16'd0;
      xform_reg = XF_NONE;
      key_reg = 16'd0;
      key_en_reg = 1'b0;
      errors = 0;
      transfers = 0;
      results = 0;
      fills = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      transfers_o <= 0;
      results_o <= 0;
      fills_o <= 0;
    end else begin
      // register writes on the access cycle
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[PADDR_W-1:2]))
          REG_WIDTH:   width_reg = pwdata_i[7:0];
          REG_HEIGHT:  height_reg = pwdata_i[7:0];
          REG_DEST_X:  dest_x_reg = pwdata_i[15:0];
          REG_DEST_Y:  dest_y_reg = pwdata_i[15:0];
          REG_XFORM:   xform_reg = xform_e'(pwdata_i[1:0]);
          REG_KEY_COL: key_reg = pwdata_i[15:0];
          REG_KEY_EN:  key_en_reg = pwdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) begin
        transfers++;
        predict_pixel(op_e'(operation_i), pix_x_i, pix_y_i, pix_color_i);
      end
      fail_count_o <= errors;
      pending_o <= pixel_result_q.size();
      transfers_o <= transfers;
      results_o <= results;
      fills_o <= fills;
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import rgbfb_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1_500_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          operation_i;
  logic signed [15:0]  pix_x_i;
  logic signed [15:0]  pix_y_i;
  logic [15:0]         pix_color_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [15:0]         out_color_o;
  logic signed [15:0]  out_x_o;
  logic signed [15:0]  out_y_o;
  logic                visible_o;
  logic                in_range_o;

  int fail_count;
  int pending;
  int transfers;
  int results;
  int fills;

  int cycle_count = 0;
  int setups = 0;
  int cur_w = DEFAULT_MAX_WIDTH;
  int cur_h = DEFAULT_MAX_HEIGHT;
  logic [15:0] cur_key = 16'd0;
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  int hold_asked = 0;
  int hold_done = 0;

  // colors that survive the round trip through one byte unchanged
  logic [15:0] exact_colors [7] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                                    16'h001F, 16'h4200, 16'h000F};

  always #(HALF_PERIOD) clk_i = ~clk_i;

  rgb332_framebuffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .pix_x_i     (pix_x_i),
    .pix_y_i     (pix_y_i),
    .pix_color_i (pix_color_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_color_o (out_color_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .visible_o   (visible_o),
    .in_range_o  (in_range_o)
  );

  rgbfb_checker pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .operation_i  (operation_i),
    .pix_x_i      (pix_x_i),
    .pix_y_i      (pix_y_i),
    .pix_color_i  (pix_color_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_color_i  (out_color_o),
    .out_x_i      (out_x_o),
    .out_y_i      (out_y_o),
    .visible_i    (visible_o),
    .in_range_i   (in_range_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .transfers_o  (transfers),
    .results_o    (results),
    .fills_o      (fills)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall, plus one long hold when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= rx_idle_en && ($urandom_range(0, 99) < 17);
    end
  end

  task automatic reg_write(input reg_e r, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({r, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup_image(input logic [7:0] w, input logic [7:0] h,
                             input logic [15:0] dx, input logic [15:0] dy,
                             input xform_e xf, input logic [15:0] key, input logic key_en);
    reg_write(REG_WIDTH, {24'd0, w});
    reg_write(REG_HEIGHT, {24'd0, h});
    reg_write(REG_DEST_X, {16'd0, dx});
    reg_write(REG_DEST_Y, {16'd0, dy});
    reg_write(REG_XFORM, {30'd0, xf});
    reg_write(REG_KEY_COL, {16'd0, key});
    reg_write(REG_KEY_EN, {31'd0, key_en});
    cur_w = (w == 0) ? 1 : (w > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : int'(w);
    cur_h = (h == 0) ? 1 : (h > DEFAULT_MAX_HEIGHT) ? DEFAULT_MAX_HEIGHT : int'(h);
    cur_key = key;
    setups++;
  endtask

  // one pixel command transfer, with random idle cycles ahead of it
  task automatic send_pixel(input op_e op, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] color);
    while (tx_idle_en && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    pix_x_i <= x;
    pix_y_i <= y;
    pix_color_i <= color;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain results, then let trailing fills finish (one running, the queue full behind it)
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat ((QUEUE_DEPTH + 1) * cur_w * cur_h + 16) @(posedge clk_i);
  endtask

  task automatic random_pixels(input int count, input int fill_budget);
    op_e         op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3 && fill_budget > 0) begin
        op = OP_FILL;
        fill_budget--;
      end else if (pick < 38) op = OP_WRITE;
      else if (pick < 63) op = OP_READ;
      else op = OP_EMIT;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        x = 16'($urandom_range(0, cur_w - 1));
        y = 16'($urandom_range(0, cur_h - 1));
      end else if (pick < 90) begin
        // just inside or just outside an edge
        case ($urandom_range(0, 3))
          0: x = 16'hFFFF;
          1: x = 16'(cur_w);
          2: x = 16'd0;
          default: x = 16'(cur_w - 1);
        endcase
        y = ($urandom_range(0, 1) == 0) ? 16'(cur_h) : 16'($urandom_range(0, cur_h - 1));
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      color = ($urandom_range(0, 99) < 25) ? cur_key : 16'($urandom);
      send_pixel(op, x, y, color);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    in_valid_i = 1'b0;
    operation_i = OP_WRITE;
    pix_x_i = 16'sd0;
    pix_y_i = 16'sd0;
    pix_color_i = 16'd0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: cleared store, color corners, edges, fill
    setup_image(8'd128, 8'd128, 16'd0, 16'd0, XF_NONE, 16'd0, 1'b0);
    send_pixel(OP_READ, 16'd0, 16'd0, 16'd0);
    send_pixel(OP_EMIT, 16'd127, 16'd127, 16'd0);
    send_pixel(OP_WRITE, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(OP_READ, 16'd0, 16'd0, 16'd0);
    send_pixel(OP_WRITE, 16'd127, 16'd127, 16'h2108);
    send_pixel(OP_READ, 16'd127, 16'd127, 16'hFFFF);
    send_pixel(OP_WRITE, 16'd127, 16'd0, 16'hD6F7);
    send_pixel(OP_EMIT, 16'd127, 16'd0, 16'd0);
    send_pixel(OP_WRITE, 16'hFFFF, 16'd5, 16'hFFFF);
    send_pixel(OP_WRITE, 16'd128, 16'd5, 16'hFFFF);
    send_pixel(OP_WRITE, 16'd5, 16'h8000, 16'hFFFF);
    send_pixel(OP_WRITE, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_pixel(OP_READ, 16'hFFFF, 16'd5, 16'd0);
    send_pixel(OP_READ, 16'd5, 16'd128, 16'd0);
    send_pixel(OP_EMIT, 16'h8000, 16'h7FFF, 16'd0);
    send_pixel(OP_EMIT, 16'h7FFF, 16'hFFFF, 16'd0);
    send_pixel(OP_WRITE, 16'd3, 16'd4, 16'h0010);
    send_pixel(OP_READ, 16'd3, 16'd4, 16'd0);
    send_pixel(OP_FILL, 16'd0, 16'd0, 16'h4208);
    send_pixel(OP_READ, 16'd64, 16'd64, 16'd0);
    send_pixel(OP_EMIT, 16'd0, 16'd127, 16'd0);
    send_pixel(OP_READ, 16'd127, 16'd127, 16'd0);
    send_pixel(OP_WRITE, 16'd1, 16'd1, 16'h8000);
    send_pixel(OP_EMIT, 16'd1, 16'd1, 16'd0);
    settle();

    // small image, mirrored, keyed on red
    setup_image(8'd8, 8'd6, 16'd100, 16'hFFF9, XF_MIRR_H, 16'hF800, 1'b1);
    random_pixels(260, 4);
    settle();

    // single pixel image, extreme offsets
    setup_image(8'd1, 8'd1, 16'h7FFF, 16'h8000, XF_ROT180, 16'h0000, 1'b1);
    random_pixels(150, 4);
    settle();

    // width below range and height above range
    setup_image(8'd0, 8'd255, 16'($urandom), 16'($urandom), XF_MIRR_V, 16'hFFFF, 1'b1);
    random_pixels(150, 3);
    settle();

    // full size image
    setup_image(8'd128, 8'd128, 16'h8000, 16'h7FFF, XF_ROT180, 16'h07E0, 1'b0);
    random_pixels(220, 2);
    settle();

    // no idling, and one long hold on the result side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    setup_image(8'd16, 8'd16, 16'd0, 16'd0, XF_NONE, 16'h001F, 1'b1);
    hold_asked++;
    random_pixels(320, 4);
    settle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // width above range
    setup_image(8'd200, 8'd3, 16'h0040, 16'hFF00, XF_MIRR_H, 16'h4200, 1'b1);
    random_pixels(200, 3);
    settle();

    // random setups
    for (int p = 0; p < 3; p++) begin
      setup_image(8'($urandom_range(2, 24)), 8'($urandom_range(2, 24)),
                  16'($urandom), 16'($urandom), xform_e'($urandom_range(0, 3)),
                  exact_colors[$urandom_range(0, 6)], 1'($urandom_range(0, 1)));
      random_pixels(130, 3);
      settle();
    end

    $display("covered %0d pixel transfers including %0d fills, %0d results checked",
             transfers, fills, results);
    $display("over %0d register setups: 1x1 to 128x128, all transforms, keying, long hold",
             setups);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rgbfb_pkg.sv
rtl/core/rgbfb_front.sv
rtl/core/rgbfb_queue.sv
rtl/core/rgbfb_back.sv
rtl/core/rgb332_framebuffer.sv
rtl/core/rgbfb_checker.sv
tb/rgbfb_checker.sv
tb/testbench.sv
